[sv/sfd_pkg.sv]
// ---------------------------------------------------------------------------
// sfd_pkg: shared definitions of the sensor frame deframer
// Frame geometry, byte codes, and the types passed between the front end,
// the job queue and the drain engine.
// ---------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  // Number of range readings in a range frame.
  localparam int RANGE_COUNT = 25;

  // Words per frame kind (range frame: scan time plus readings).
  localparam int STORE_DEPTH = RANGE_COUNT + 1;
  localparam int ENC_WORDS   = 2;

  // Word index inside one bank, and RAM address (bank bit on top).
  localparam int IDX_W     = $clog2(STORE_DEPTH);
  localparam int RAM_AW    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  // Byte position within a frame; the end byte sits at 4 * words + 7.
  localparam int POS_W   = 8;
  localparam int ENC_END = 4 * ENC_WORDS + 7;
  localparam int RNG_END = 4 * STORE_DEPTH + 7;

  // Width of the word index output field.
  localparam int WIDX_W = 5;

  // Byte codes on the serial link.
  localparam logic [7:0] HDR_BYTE     = 8'd13;
  localparam logic [7:0] HDR_ZERO     = 8'd0;
  localparam logic [7:0] TYPE_ENCODER = 8'd1;
  localparam logic [7:0] TYPE_RANGE   = 8'd2;
  localparam logic [7:0] END_BYTE     = 8'd10;

  // Frame kind codes as reported on the output.
  localparam logic KIND_ENCODER = 1'b0;
  localparam logic KIND_RANGE   = 1'b1;

  // One accepted frame waiting to be drained.
  typedef struct packed {
    logic kind;
    logic bank;
  } job_t;

  // Write request from the front end into the word store.
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [31:0]       data;
  } ram_wr_t;

endpackage

`default_nettype wire

[sv/sfd_ram.sv]
// ---------------------------------------------------------------------------
// sfd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/sfd_front.sv]
// ---------------------------------------------------------------------------
// sfd_front: header hunt and word assembly
// Accepts bytes, finds frame headers, packs payload words into the store
// and posts a job for every frame whose end byte checks out.
// ---------------------------------------------------------------------------
`default_nettype none

module sfd_front
  import sfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_job,
  output ram_wr_t         ram_wr
);

  typedef enum logic [3:0] {
    HUNT_FIRST  = 4'b0001,
    HUNT_SECOND = 4'b0010,
    HUNT_ZERO   = 4'b0100,
    HUNT_TYPE   = 4'b1000
  } hunt_t;

  localparam logic [POS_W-1:0] ENC_END_P = POS_W'(ENC_END);
  localparam logic [POS_W-1:0] RNG_END_P = POS_W'(RNG_END);
  localparam logic [POS_W-1:0] FIRST_P   = POS_W'(4);
  localparam logic [POS_W-1:0] TYPE_P    = POS_W'(3);

  hunt_t             hunt_r, hunt_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic              kind_r, kind_nxt;
  logic              bank_r, bank_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [23:0]       asm_r, asm_nxt;

  logic              accept;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  end_pos;
  logic [POS_W-1:0]  pos_off;
  logic [1:0]        lane;
  logic [IDX_W-1:0]  idx;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pos_inc  = pos_r + 1'b1;
  assign end_pos  = (kind_r == KIND_RANGE) ? RNG_END_P : ENC_END_P;
  assign pos_off  = pos_inc - FIRST_P;
  assign lane     = pos_off[1:0];
  assign idx      = pos_off[IDX_W+1:2];

  always_comb begin
    hunt_nxt     = hunt_r;
    in_frame_nxt = in_frame_r;
    kind_nxt     = kind_r;
    bank_nxt     = bank_r;
    pos_nxt      = pos_r;
    asm_nxt      = asm_r;
    q_push       = 1'b0;
    q_job        = '{kind: kind_r, bank: bank_r};
    ram_wr       = '{en: 1'b0, addr: {bank_r, idx}, data: {in_rx_byte, asm_r}};

    if (accept) begin
      if (!in_frame_r) begin
        case (hunt_r)
          HUNT_FIRST: begin
            if (in_rx_byte == HDR_BYTE) hunt_nxt = HUNT_SECOND;
          end
          HUNT_SECOND: begin
            hunt_nxt = (in_rx_byte == HDR_BYTE) ? HUNT_ZERO : HUNT_FIRST;
          end
          HUNT_ZERO: begin
            hunt_nxt = (in_rx_byte == HDR_ZERO) ? HUNT_TYPE : HUNT_FIRST;
          end
          HUNT_TYPE: begin
            if (in_rx_byte == TYPE_ENCODER || in_rx_byte == TYPE_RANGE) begin
              in_frame_nxt = 1'b1;
              kind_nxt     = (in_rx_byte == TYPE_RANGE) ? KIND_RANGE : KIND_ENCODER;
              pos_nxt      = TYPE_P;
              asm_nxt      = '0;
            end
            hunt_nxt = HUNT_FIRST;
          end
          default: begin
            hunt_nxt = HUNT_FIRST;
          end
        endcase
      end else begin
        pos_nxt = pos_inc;
        if (pos_inc >= end_pos) begin
          // End byte: the frame is posted only if it carries the end marker.
          in_frame_nxt = 1'b0;
          hunt_nxt     = HUNT_FIRST;
          pos_nxt      = '0;
          if (in_rx_byte == END_BYTE) begin
            q_push   = 1'b1;
            bank_nxt = !bank_r;
          end
        end else if (pos_inc >= FIRST_P && pos_inc < end_pos - POS_W'(3)) begin
          case (lane)
            2'd0:    asm_nxt = {16'd0, in_rx_byte};
            2'd1:    asm_nxt = asm_r | {8'd0, in_rx_byte, 8'd0};
            2'd2:    asm_nxt = asm_r | {in_rx_byte, 16'd0};
            default: ram_wr.en = 1'b1;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r     <= HUNT_FIRST;
      in_frame_r <= 1'b0;
      kind_r     <= KIND_ENCODER;
      bank_r     <= 1'b0;
      pos_r      <= '0;
      asm_r      <= '0;
    end else begin
      hunt_r     <= hunt_nxt;
      in_frame_r <= in_frame_nxt;
      kind_r     <= kind_nxt;
      bank_r     <= bank_nxt;
      pos_r      <= pos_nxt;
      asm_r      <= asm_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/sfd_job_queue.sv]
// ---------------------------------------------------------------------------
// sfd_job_queue: two-entry queue of accepted frames
// The head entry stays until the drain engine has moved its last word into
// the output register, so a full queue means both store banks are still in use.
// ---------------------------------------------------------------------------
`default_nettype none

module sfd_job_queue
  import sfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  output logic      head_valid,
  output job_t      head_job,
  input  wire logic pop
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/sfd_drain.sv]
// ---------------------------------------------------------------------------
// sfd_drain: word drain engine
// Reads the words of the head frame out of the store one by one and hands
// them to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sfd_drain
  import sfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  job_t                    q_head,
  output logic                    q_pop,
  output logic                    rd_en,
  output logic [RAM_AW-1:0]       rd_addr,
  input  wire logic [31:0]        rd_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_frame_kind,
  output logic [WIDX_W-1:0]       out_word_index,
  output logic signed [31:0]      out_word_value,
  output logic                    out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } drain_state_t;

  localparam logic [IDX_W-1:0] ENC_LAST = IDX_W'(ENC_WORDS - 1);
  localparam logic [IDX_W-1:0] RNG_LAST = IDX_W'(STORE_DEPTH - 1);

  drain_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic               ov_r, ov_nxt;
  logic               kind_r;
  logic [WIDX_W-1:0]  idx_r;
  logic [31:0]        val_r;
  logic               last_r;

  logic               is_last;
  logic               slot_free;
  logic               load;

  assign is_last   = (k_r == ((q_head.kind == KIND_RANGE) ? RNG_LAST : ENC_LAST));
  assign slot_free = !ov_r || out_ready;
  assign load      = (state_r == S_LOAD) && slot_free;
  assign rd_en     = (state_r == S_READ);
  assign rd_addr   = {q_head.bank, k_r};
  assign q_pop     = load && is_last;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          k_nxt     = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= q_head.kind;
      idx_r  <= WIDX_W'(k_r);
      val_r  <= rd_data;
      last_r <= is_last;
    end
  end

  assign out_valid      = ov_r;
  assign out_frame_kind = kind_r;
  assign out_word_index = idx_r;
  assign out_word_value = signed'(val_r);
  assign out_last_word  = last_r;

endmodule

`default_nettype wire

[sv/sensor_frame_deframer_unit.sv]
// ---------------------------------------------------------------------------
// sensor_frame_deframer_unit: serial deframer for encoder and range frames
// Hunts for frame headers in a received byte stream and emits the payload
// words of every frame that ends with a valid end marker.
// ---------------------------------------------------------------------------
// Usage notes.
// The input channel (in_valid, in_ready, in_rx_byte) takes one received byte
// per transfer. The block looks for the header 13, 13, 0 and a type byte: type 1
// opens an encoder frame of 16 bytes, type 2 a range frame of 112 bytes.
// Bytes from position 4 onward form little-endian signed 32-bit words.
// When the end byte of a frame equals 10, the output channel (out_valid,
// out_ready and the out_ fields) delivers every word of that frame in order,
// with out_last_word set on the final one. Any other end byte drops the frame.
// Bytes may arrive back to back while in_ready is high. After the end byte
// of a frame is taken, the drain engine reads each word through the
// registered store read and then loads it into the output register; it
// fetches the next word only once the current one is loaded.
// Two finished frames can wait for draining in separate store banks; only
// when both banks are held does in_ready drop, until the last word of the
// older one has moved into the output register.
// A stall by the receiver holds the current word in the output register.
// Reset (rst_n low, synchronous) empties the queue, drops any partial frame
// and restarts the header hunt; the word store itself is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module sensor_frame_deframer_unit
  import sfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_frame_kind,
  output logic [WIDX_W-1:0]      out_word_index,
  output logic signed [31:0]     out_word_value,
  output logic                   out_last_word
);

  // Front end to queue and store.
  logic    q_push;
  job_t    q_job;
  logic    q_full;
  ram_wr_t ram_wr;

  // Queue head to the drain engine.
  logic    q_valid;
  job_t    q_head;
  logic    q_pop;

  // Store read port.
  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [31:0]       rd_data;

  // The front end parses bytes and fills the bank it currently owns.
  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job),
    .ram_wr     (ram_wr)
  );

  // Accepted frames wait here; an entry leaves when its last word enters the output register.
  sfd_job_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .head_valid (q_valid),
    .head_job   (q_head),
    .pop        (q_pop)
  );

  // Word store: two banks of frame words, bank select on the top address bit.
  sfd_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The drain engine walks the head frame and feeds the output register.
  sfd_drain u_drain (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_kind (out_frame_kind),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_last_word  (out_last_word)
  );

endmodule

`default_nettype wire

[sv/sfd_checker.sv]
// ---------------------------------------------------------------------------
// sfd_port_checks: port-level checks of the deframer
// Watches the top-level ports and flags frame shapes that cannot occur.
// ---------------------------------------------------------------------------
`default_nettype none

module sfd_port_checks
  import sfd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_frame_kind,
  input wire logic [WIDX_W-1:0] out_word_index,
  input wire logic signed [31:0] out_word_value,
  input wire logic              out_last_word
);

  localparam logic [WIDX_W-1:0] ENC_LAST_IDX = WIDX_W'(ENC_WORDS - 1);
  localparam logic [WIDX_W-1:0] RNG_LAST_IDX = WIDX_W'(STORE_DEPTH - 1);

  // No word is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled word keeps its value and stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_word_value) && $stable(out_word_index))
    else $error("stalled output word changed");

  // Encoder frames carry only two words.
  a_enc_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind == KIND_ENCODER |->
      out_word_index <= ENC_LAST_IDX)
    else $error("encoder word index out of range");

  // The last word of a frame sits at the frame's final index.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_word |->
      (out_frame_kind == KIND_ENCODER && out_word_index == ENC_LAST_IDX) ||
      (out_frame_kind == KIND_RANGE && out_word_index == RNG_LAST_IDX))
    else $error("last word at wrong index");

  // After a non-last word is taken, a word shown right behind it must carry the next index and the same kind.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word ##1 out_valid |->
      out_word_index == $past(out_word_index) + 1'b1 &&
      out_frame_kind == $past(out_frame_kind))
    else $error("word index did not advance by one");

endmodule

bind sensor_frame_deframer_unit sfd_port_checks u_sfd_port_checks (.*);

`default_nettype wire
